// ===== sv/gbs_pkg.sv =====
// Shared types and constants for the greedy box suppression block.
package gbs_pkg;

    localparam int COORD_W   = 16;
    localparam int SIZE_W    = 15;
    localparam int AREA_W    = 30;
    localparam int THR_W     = 9;
    localparam int INDEX_W   = 10;
    localparam int UNION_W   = 31;
    localparam int PROD_W    = 40;
    localparam int SCALE_SH  = 8;

    localparam logic [THR_W-1:0] THR_RESET = 9'd115;

    typedef struct packed {
        logic signed [COORD_W-1:0] box_left;
        logic signed [COORD_W-1:0] box_top;
        logic [SIZE_W-1:0]         box_width;
        logic [SIZE_W-1:0]         box_height;
        logic                      frame_end;
    } t_box;

    typedef struct packed {
        logic               keep;
        logic [INDEX_W-1:0] box_index;
        logic               overflow;
        logic               frame_done;
    } t_result;

    typedef struct packed {
        logic [SIZE_W-1:0]         height;
        logic [SIZE_W-1:0]         width;
        logic signed [COORD_W-1:0] top;
        logic signed [COORD_W-1:0] left;
    } t_kept;

    typedef struct packed {
        logic load;
        logic issue;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic issue_last;
        logic pipe_busy;
        logic out_free;
    } t_status;

endpackage

// ===== sv/gbs_box_if.sv =====
// Request channel carrying one detection box.
interface gbs_box_if
    import gbs_pkg::*;
();
    logic valid;
    logic ready;
    t_box data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gbs_result_if.sv =====
// Request channel carrying one suppression verdict.
interface gbs_result_if
    import gbs_pkg::*;
();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== sv/gbs_ctrl.sv =====
// Sequencing state machine: accept, scan of the kept store, drain and commit.
module gbs_ctrl
    import gbs_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_SCAN  = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!i_status.empty) begin
                    o_cmd.issue = 1'b1;
                end
                if (i_status.empty || i_status.issue_last) begin
                    n_state = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                if (!i_status.pipe_busy && i_status.out_free) begin
                    o_cmd.commit = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_load_starts_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> r_state == ST_SCAN)
        else $error("load did not start a scan");

    a_commit_waits_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.commit |-> !i_status.pipe_busy && i_status.out_free)
        else $error("commit while compare pipeline busy or output full");

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.load, o_cmd.issue, o_cmd.commit}))
        else $error("more than one command at once");

endmodule

// ===== sv/gbs_datapath.sv =====
// Kept-box store, overlap compare pipeline, counters and result register.
module gbs_datapath
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT  = 64,
    parameter int MAX_BOXES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_cmd             i_cmd,
    input  t_box             i_box,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata,
    output t_status          o_status,
    output logic             o_result_valid,
    output t_result          o_result,
    input  logic             i_result_ready
);

    localparam int ADDR_W = (MAX_KEPT > 1) ? $clog2(MAX_KEPT) : 1;
    localparam int CNT_W  = $clog2(MAX_KEPT + 1);
    localparam int POS_W  = $clog2(MAX_BOXES);

    t_kept             mem_box  [MAX_KEPT];
    logic [AREA_W-1:0] mem_area [MAX_KEPT];

    logic [THR_W-1:0]  r_thr;
    logic [CNT_W-1:0]  r_count;
    logic [POS_W-1:0]  r_pos;
    logic [ADDR_W-1:0] r_idx;
    t_kept             r_box;
    logic [AREA_W-1:0] r_area;
    logic              r_last;
    logic              r_hit;

    logic              r_v1, r_v2, r_v3, r_v4, r_v5;
    t_kept             r_kb;
    logic [AREA_W-1:0] r_ka1, r_ka2, r_ka3;
    logic [SIZE_W-1:0] r_iw, r_ih;
    logic [AREA_W-1:0] r_inter3, r_inter4, r_inter5;
    logic [UNION_W-1:0] r_uni;
    logic [PROD_W-1:0] r_prod;

    logic              r_out_valid;
    t_result           r_out;

    logic signed [COORD_W:0] ax0, ax1, ay0, ay1, bx0, bx1, by0, by1;
    logic signed [COORD_W:0] x_lo, x_hi, y_lo, y_hi, iw_full, ih_full;
    logic                    disjoint;
    logic                    store;
    logic                    keep;
    logic [POS_W+INDEX_W-1:0] pos_ext;

    // Overlap extent of the current box against the entry just read.
    always_comb begin
        ax0 = {r_box.left[COORD_W-1], r_box.left};
        ay0 = {r_box.top[COORD_W-1], r_box.top};
        ax1 = ax0 + $signed({2'b00, r_box.width});
        ay1 = ay0 + $signed({2'b00, r_box.height});
        bx0 = {r_kb.left[COORD_W-1], r_kb.left};
        by0 = {r_kb.top[COORD_W-1], r_kb.top};
        bx1 = bx0 + $signed({2'b00, r_kb.width});
        by1 = by0 + $signed({2'b00, r_kb.height});
        disjoint = (ax0 > bx1) || (ax1 < bx0) || (ay0 > by1) || (ay1 < by0);
        x_lo = (ax0 > bx0) ? ax0 : bx0;
        x_hi = (ax1 < bx1) ? ax1 : bx1;
        y_lo = (ay0 > by0) ? ay0 : by0;
        y_hi = (ay1 < by1) ? ay1 : by1;
        iw_full = x_hi - x_lo;
        ih_full = y_hi - y_lo;
    end

    assign keep    = !r_hit;
    assign store   = keep && (r_count < CNT_W'(MAX_KEPT));
    assign pos_ext = {{INDEX_W{1'b0}}, r_pos};

    assign o_status.empty      = (r_count == '0);
    assign o_status.issue_last = (CNT_W'(r_idx) == r_count - CNT_W'(1));
    assign o_status.pipe_busy  = r_v1 || r_v2 || r_v3 || r_v4 || r_v5;
    assign o_status.out_free   = !r_out_valid || i_result_ready;

    assign o_result_valid = r_out_valid;
    assign o_result       = r_out;

    // Store access: registered read during the scan, write on commit of a kept box while there is room.
    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_kb  <= mem_box[r_idx];
            r_ka1 <= mem_area[r_idx];
        end
        if (i_cmd.commit && store) begin
            mem_box[r_count[ADDR_W-1:0]]  <= r_box;
            mem_area[r_count[ADDR_W-1:0]] <= r_area;
        end
    end

    // Compare pipeline payload.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_box.left   <= i_box.box_left;
            r_box.top    <= i_box.box_top;
            r_box.width  <= i_box.box_width;
            r_box.height <= i_box.box_height;
            r_area       <= AREA_W'(i_box.box_width) * AREA_W'(i_box.box_height);
            r_last       <= i_box.frame_end;
        end
        r_iw     <= disjoint ? '0 : iw_full[SIZE_W-1:0];
        r_ih     <= disjoint ? '0 : ih_full[SIZE_W-1:0];
        r_ka2    <= r_ka1;
        r_inter3 <= AREA_W'(r_iw) * AREA_W'(r_ih);
        r_ka3    <= r_ka2;
        r_uni    <= UNION_W'(r_area) + UNION_W'(r_ka3) - UNION_W'(r_inter3);
        r_inter4 <= r_inter3;
        r_prod   <= PROD_W'(r_thr) * PROD_W'(r_uni);
        r_inter5 <= r_inter4;
        if (i_cmd.commit) begin
            r_out.keep       <= keep;
            r_out.box_index  <= pos_ext[INDEX_W-1:0];
            r_out.overflow   <= keep && !store;
            r_out.frame_done <= r_last;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr       <= THR_RESET;
            r_count     <= '0;
            r_pos       <= '0;
            r_idx       <= '0;
            r_hit       <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_v3        <= 1'b0;
            r_v4        <= 1'b0;
            r_v5        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            r_v1 <= i_cmd.issue;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
            if (i_cmd.load) begin
                r_idx <= '0;
                r_hit <= 1'b0;
            end else begin
                if (i_cmd.issue) begin
                    r_idx <= r_idx + ADDR_W'(1);
                end
                if (r_v5 && (PROD_W'({r_inter5, {SCALE_SH{1'b0}}}) > r_prod)) begin
                    r_hit <= 1'b1;
                end
            end
            if (i_cmd.commit) begin
                r_out_valid <= 1'b1;
                if (r_last) begin
                    r_count <= '0;
                    r_pos   <= '0;
                end else begin
                    if (store) begin
                        r_count <= r_count + CNT_W'(1);
                    end
                    r_pos <= (r_pos == POS_W'(MAX_BOXES - 1)) ? '0 : r_pos + POS_W'(1);
                end
            end else if (i_result_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_KEPT))
        else $error("kept count beyond store depth");

    a_overflow_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.overflow && !r_out.keep))
        else $error("overflow flagged on a suppressed box");

    a_frame_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.commit && r_last |=> r_count == '0 && r_pos == '0)
        else $error("store not cleared after frame end");

endmodule

// ===== sv/greedy_box_suppression_top.sv =====
// Top level of the greedy box suppression block.
// Boxes of one frame arrive in descending score order; each is compared against
// every box kept so far in the frame and dropped if intersection*256 exceeds
// threshold*union for any of them. One box is in work at a time: the next box
// is accepted only after the current one is scanned and drained. The scan
// makes one kept-box memory read per cycle, feeding a single five-stage overlap
// compare pipeline. The verdict sits in an output register, so the next
// box is accepted while the result waits; that box then holds in its drain
// until the waiting result is taken. Up to MAX_KEPT boxes are stored per
// frame; the store clears after the box marked frame_end.
module greedy_box_suppression_top
    import gbs_pkg::*;
#(
    parameter int MAX_KEPT  = 64,
    parameter int MAX_BOXES = 1024
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    gbs_box_if.sink          i_box,
    gbs_result_if.source     o_result,
    input  logic             i_cfg_we,
    input  logic [THR_W-1:0] i_cfg_wdata
);

    t_cmd    cmd;
    t_status status;

    gbs_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_box.valid),
        .o_in_ready (i_box.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    gbs_datapath #(
        .MAX_KEPT  (MAX_KEPT),
        .MAX_BOXES (MAX_BOXES)
    ) u_datapath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_box          (i_box.data),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_status       (status),
        .o_result_valid (o_result.valid),
        .o_result       (o_result.data),
        .i_result_ready (o_result.ready)
    );

endmodule
